@@ hdl/prp_pkg.sv @@
package prp_pkg;

    localparam int COORD_BITS_DEF = 21;

    // configuration port
    localparam int CFG_W = 63;
    localparam int IDX_W = 3;

    typedef enum logic [IDX_W-1:0] {
        REG_CENTER  = 3'd0,
        REG_SCALE   = 3'd1,
        REG_SINE    = 3'd2,
        REG_COSINE  = 3'd3,
        REG_SHIFT   = 3'd4,
        REG_SCREEN  = 3'd5,
        REG_PERSP   = 3'd6,
        REG_VDIST   = 3'd7
    } t_cfg_idx;

    localparam int Q_W_CFG  = 48;
    localparam int SCR_W    = 24;
    localparam int VD_W     = 20;

    localparam logic [CFG_W-1:0]   CENTER_RST = '0;
    localparam logic [Q_W_CFG-1:0] SCALE_RST  = 48'd4311810304;
    localparam logic [Q_W_CFG-1:0] SINE_RST   = '0;
    localparam logic [Q_W_CFG-1:0] COSINE_RST = 48'd70369817935872;
    localparam logic [CFG_W-1:0]   SHIFT_RST  = 63'd3221225472000;
    localparam logic [SCR_W-1:0]   SCREEN_RST = 24'd409700;
    localparam logic [VD_W-1:0]    VDIST_RST  = 20'd1000;

    // datapath widths (values carry 8 fraction bits until projection)
    localparam int Q_FW    = 16;
    localparam int S_W     = 41;
    localparam int T_W     = 44;
    localparam int A_W     = 46;
    localparam int Q_W     = 50;
    localparam int DIV_W   = 49;
    localparam int PROD_W  = 62;
    localparam int NUM_W   = 62;
    localparam int QUO_W   = 25;
    localparam int HALF_W  = 11;
    localparam int OUT_W   = 24;
    localparam int TAG_W   = OUT_W + 4;

    localparam logic signed [63:0] LIM40   = 64'sd1099511627775;
    localparam logic signed [63:0] OUT_MAX = 64'sd8388607;
    localparam logic signed [63:0] OUT_MIN = -64'sd8388608;

    function automatic logic signed [63:0] rnd14(input logic signed [63:0] v);
        return (v + 64'sd8192) >>> 14;
    endfunction

    // returns {clip, value}
    function automatic logic [S_W:0] sat_lim(input logic signed [63:0] v);
        logic [S_W:0] r;
        if (v > LIM40) begin
            r = {1'b1, LIM40[S_W-1:0]};
        end else if (v < -LIM40) begin
            r = {1'b1, S_W'(-LIM40)};
        end else begin
            r = {1'b0, v[S_W-1:0]};
        end
        return r;
    endfunction

    function automatic logic [OUT_W:0] sat_out(input logic signed [63:0] v);
        logic [OUT_W:0] r;
        if (v > OUT_MAX) begin
            r = {1'b1, OUT_MAX[OUT_W-1:0]};
        end else if (v < OUT_MIN) begin
            r = {1'b1, OUT_MIN[OUT_W-1:0]};
        end else begin
            r = {1'b0, v[OUT_W-1:0]};
        end
        return r;
    endfunction

endpackage

@@ hdl/prp_div.sv @@
module prp_div #(
    parameter int DW = prp_pkg::DIV_W,
    parameter int NW = prp_pkg::NUM_W,
    parameter int QB = prp_pkg::QUO_W,
    parameter int TW = prp_pkg::TAG_W
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  logic [NW-1:0] i_num_x,
    input  logic [NW-1:0] i_num_y,
    input  logic [DW-1:0] i_den,
    input  logic [TW-1:0] i_tag,
    output logic          o_vld,
    output logic [QB-1:0] o_quo_x,
    output logic [QB-1:0] o_quo_y,
    output logic [TW-1:0] o_tag
);
    import prp_pkg::*;

    localparam int RW = DW + QB + 1;

    logic          r_vld [0:QB];
    logic [RW-1:0] r_rx  [0:QB];
    logic [RW-1:0] r_ry  [0:QB];
    logic [DW-1:0] r_den [0:QB];
    logic [QB-1:0] r_qx  [0:QB];
    logic [QB-1:0] r_qy  [0:QB];
    logic          r_ox  [0:QB];
    logic          r_oy  [0:QB];
    logic [TW-1:0] r_tag [0:QB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
        end
        r_rx[0]  <= RW'(i_num_x);
        r_ry[0]  <= RW'(i_num_y);
        r_den[0] <= i_den;
        r_qx[0]  <= '0;
        r_qy[0]  <= '0;
        r_ox[0]  <= 1'b0;
        r_oy[0]  <= 1'b0;
        r_tag[0] <= i_tag;
    end

    // one quotient bit per stage, most significant first
    for (genvar j = 0; j < QB; j++) begin : g_stage
        localparam int B = QB - 1 - j;
        logic [RW-1:0] dsh;
        logic [RW-1:0] dfull;
        logic          gex;
        logic          gey;
        logic          ovx;
        logic          ovy;

        assign dsh   = RW'(r_den[j]) << B;
        assign dfull = RW'(r_den[j]) << QB;
        assign gex   = r_rx[j] >= dsh;
        assign gey   = r_ry[j] >= dsh;
        // quotient too wide for the output range: flag it on the first stage
        assign ovx   = r_ox[j] | ((j == 0) && (r_rx[j] >= dfull));
        assign ovy   = r_oy[j] | ((j == 0) && (r_ry[j] >= dfull));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j+1] <= 1'b0;
            end else begin
                r_vld[j+1] <= r_vld[j];
            end
            r_rx[j+1]  <= gex ? r_rx[j] - dsh : r_rx[j];
            r_ry[j+1]  <= gey ? r_ry[j] - dsh : r_ry[j];
            r_qx[j+1]  <= r_qx[j] | (QB'(gex) << B);
            r_qy[j+1]  <= r_qy[j] | (QB'(gey) << B);
            r_den[j+1] <= r_den[j];
            r_ox[j+1]  <= ovx;
            r_oy[j+1]  <= ovy;
            r_tag[j+1] <= r_tag[j];
        end
    end

    assign o_vld   = r_vld[QB];
    assign o_quo_x = r_ox[QB] ? {QB{1'b1}} : r_qx[QB];
    assign o_quo_y = r_oy[QB] ? {QB{1'b1}} : r_qy[QB];
    assign o_tag   = r_tag[QB];

endmodule

@@ hdl/point_rotate_project.sv @@
// Throughput: one point per cycle, o_busy stays low; the 25-stage projection divider
// (one quotient bit per stage) sets the depth of the pipeline.
// Reset (i_rst_n low at a clock edge) clears all valid bits and loads the register defaults.
// Results are strobed for one cycle; the receiver cannot stall them.
module point_rotate_project #(
    parameter int COORD_BITS = prp_pkg::COORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic signed [COORD_BITS-1:0]      i_point_x,
    input  logic signed [COORD_BITS-1:0]      i_point_y,
    input  logic signed [COORD_BITS-1:0]      i_point_z,
    input  logic                              i_cfg_we,
    input  logic [prp_pkg::IDX_W-1:0]         i_cfg_index,
    input  logic [prp_pkg::CFG_W-1:0]         i_cfg_data,
    output logic                              o_valid,
    output logic signed [prp_pkg::OUT_W-1:0]  o_screen_x,
    output logic signed [prp_pkg::OUT_W-1:0]  o_screen_y,
    output logic signed [prp_pkg::OUT_W-1:0]  o_depth,
    output logic                              o_divisor_invalid,
    output logic                              o_clipped
);
    import prp_pkg::*;

    localparam int C    = COORD_BITS;
    localparam int D_W  = C + 1;
    localparam int P_W  = C + 1 + Q_FW;
    localparam int PADW = 3 * C + CFG_W;
    localparam int M4_W = S_W + Q_FW;
    localparam int M6_W = T_W + Q_FW;
    localparam int M8_W = A_W + Q_FW;

    // configuration registers
    logic [CFG_W-1:0]   r_center;
    logic [Q_W_CFG-1:0] r_scale;
    logic [Q_W_CFG-1:0] r_sine;
    logic [Q_W_CFG-1:0] r_cosine;
    logic [CFG_W-1:0]   r_shift;
    logic [SCR_W-1:0]   r_screen;
    logic               r_persp;
    logic [VD_W-1:0]    r_vdist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center <= CENTER_RST;
            r_scale  <= SCALE_RST;
            r_sine   <= SINE_RST;
            r_cosine <= COSINE_RST;
            r_shift  <= SHIFT_RST;
            r_screen <= SCREEN_RST;
            r_persp  <= 1'b1;
            r_vdist  <= VDIST_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                REG_CENTER: r_center <= i_cfg_data;
                REG_SCALE:  r_scale  <= i_cfg_data[Q_W_CFG-1:0];
                REG_SINE:   r_sine   <= i_cfg_data[Q_W_CFG-1:0];
                REG_COSINE: r_cosine <= i_cfg_data[Q_W_CFG-1:0];
                REG_SHIFT:  r_shift  <= i_cfg_data;
                REG_SCREEN: r_screen <= i_cfg_data[SCR_W-1:0];
                REG_PERSP:  r_persp  <= i_cfg_data[0];
                REG_VDIST:  r_vdist  <= i_cfg_data[VD_W-1:0];
                default: ;
            endcase
        end
    end

    // unpack fields; bits beyond the register read as zero
    logic [PADW-1:0]        center_pad;
    logic [PADW-1:0]        shift_pad;
    logic signed [C-1:0]    cen [3];
    logic signed [C-1:0]    shf [3];
    logic signed [Q_FW-1:0] scl [3];
    logic signed [Q_FW-1:0] sn  [3];
    logic signed [Q_FW-1:0] cs  [3];
    logic signed [C-1:0]    pt  [3];

    assign center_pad = {{(3*C){1'b0}}, r_center};
    assign shift_pad  = {{(3*C){1'b0}}, r_shift};
    assign pt[0] = i_point_x;
    assign pt[1] = i_point_y;
    assign pt[2] = i_point_z;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            cen[k] = center_pad[k*C +: C];
            shf[k] = shift_pad[k*C +: C];
            scl[k] = r_scale[k*Q_FW +: Q_FW];
            sn[k]  = r_sine[k*Q_FW +: Q_FW];
            cs[k]  = r_cosine[k*Q_FW +: Q_FW];
        end
    end

    logic acc;
    assign o_busy = 1'b0;
    assign acc    = i_start & ~o_busy;

    logic [11:1] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[10:1], acc};
        end
    end

    // stage 1: subtract center
    logic signed [D_W-1:0] r_d [3];
    // stage 2: scale
    logic signed [P_W-1:0] r_p [3];
    // stage 3: saturate
    logic signed [S_W-1:0] r_s [3];
    logic                  r_clip3;
    logic signed [S_W-1:0] n_s [3];
    logic                  n_clip3;

    always_comb begin
        logic [S_W:0] st;
        n_clip3 = 1'b0;
        for (int k = 0; k < 3; k++) begin
            st      = sat_lim(64'(r_p[k]));
            n_s[k]  = st[S_W-1:0];
            n_clip3 = n_clip3 | st[S_W];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_d[k] <= D_W'(pt[k]) - D_W'(cen[k]);
            r_p[k] <= r_d[k] * scl[k];
            r_s[k] <= n_s[k];
        end
        r_clip3 <= n_clip3;
    end

    // stages 4-5: rotate about z
    logic signed [M4_W-1:0] r_m4a, r_m4b, r_m4c, r_m4d;
    logic signed [S_W-1:0]  r_s2_4, r_s2_5;
    logic                   r_clip4, r_clip5;
    logic signed [T_W-1:0]  r_t5, r_b5;
    logic signed [63:0]     n_t, n_b;

    assign n_t = rnd14(64'(r_m4a) + 64'(r_m4b));
    assign n_b = rnd14(64'(r_m4c) - 64'(r_m4d));

    always_ff @(posedge i_clk) begin
        r_m4a   <= cs[2] * r_s[0];
        r_m4b   <= sn[2] * r_s[1];
        r_m4c   <= cs[2] * r_s[1];
        r_m4d   <= sn[2] * r_s[0];
        r_s2_4  <= r_s[2];
        r_clip4 <= r_clip3;
        r_t5    <= n_t[T_W-1:0];
        r_b5    <= n_b[T_W-1:0];
        r_s2_5  <= r_s2_4;
        r_clip5 <= r_clip4;
    end

    // stages 6-7: rotate about y, add x shift
    logic signed [M6_W-1:0] r_m6a, r_m6b, r_m6c, r_m6d;
    logic signed [T_W-1:0]  r_b6, r_b7;
    logic                   r_clip6, r_clip7;
    logic signed [A_W-1:0]  r_a7;
    logic signed [Q_W-1:0]  r_qx7;
    logic signed [63:0]     n_a, n_qx;

    assign n_a  = rnd14(64'(r_m6a) + 64'(r_m6b));
    assign n_qx = rnd14(64'(r_m6c) - 64'(r_m6d)) + (64'(shf[0]) <<< 8);

    always_ff @(posedge i_clk) begin
        r_m6a   <= cs[1] * r_s2_5;
        r_m6b   <= sn[1] * r_t5;
        r_m6c   <= cs[1] * r_t5;
        r_m6d   <= sn[1] * r_s2_5;
        r_b6    <= r_b5;
        r_clip6 <= r_clip5;
        r_a7    <= n_a[A_W-1:0];
        r_qx7   <= n_qx[Q_W-1:0];
        r_b7    <= r_b6;
        r_clip7 <= r_clip6;
    end

    // stages 8-9: rotate about x, add y and z shifts
    logic signed [M8_W-1:0] r_m8a, r_m8b, r_m8c, r_m8d;
    logic signed [Q_W-1:0]  r_qx8, r_qx9, r_qy9, r_qz9;
    logic                   r_clip8, r_clip9;
    logic signed [63:0]     n_qy, n_qz;

    assign n_qy = rnd14(64'(r_m8a) + 64'(r_m8b)) + (64'(shf[1]) <<< 8);
    assign n_qz = rnd14(64'(r_m8c) - 64'(r_m8d)) + (64'(shf[2]) <<< 8);

    always_ff @(posedge i_clk) begin
        r_m8a   <= sn[0] * r_a7;
        r_m8b   <= cs[0] * r_b7;
        r_m8c   <= cs[0] * r_a7;
        r_m8d   <= sn[0] * r_b7;
        r_qx8   <= r_qx7;
        r_clip8 <= r_clip7;
        r_qx9   <= r_qx8;
        r_qy9   <= n_qy[Q_W-1:0];
        r_qz9   <= n_qz[Q_W-1:0];
        r_clip9 <= r_clip8;
    end

    // stage 10: depth, divisor check, limit qx and qy
    logic [OUT_W:0]         n_dep;
    logic signed [63:0]     n_div;
    logic                   n_bad;
    logic [S_W:0]           n_qxs, n_qys;
    logic signed [S_W-1:0]  r_qxs10, r_qys10;
    logic [OUT_W-1:0]       r_dep10, r_dep11;
    logic                   r_bad10, r_bad11;
    logic                   r_clip10, r_clip11;
    logic [DIV_W-1:0]       r_den10, r_den11;

    assign n_dep = sat_out((64'(r_qz9) + 64'sd128) >>> 8);
    assign n_div = r_persp ? 64'(r_qz9) : (64'(shf[2]) <<< 8);
    assign n_bad = n_div <= 64'sd0;
    assign n_qxs = sat_lim(64'(r_qx9));
    assign n_qys = sat_lim(64'(r_qy9));

    // stage 11: multiply by view distance
    logic signed [VD_W:0]     vd_s;
    logic signed [PROD_W-1:0] r_px11, r_py11;

    assign vd_s = {1'b0, r_vdist};

    always_ff @(posedge i_clk) begin
        r_dep10  <= n_dep[OUT_W-1:0];
        r_bad10  <= n_bad;
        r_qxs10  <= n_qxs[S_W-1:0];
        r_qys10  <= n_qys[S_W-1:0];
        r_den10  <= n_div[DIV_W-1:0];
        r_clip10 <= r_clip9 | n_dep[OUT_W] | (~n_bad & (n_qxs[S_W] | n_qys[S_W]));
        r_px11   <= r_qxs10 * vd_s;
        r_py11   <= r_qys10 * vd_s;
        r_dep11  <= r_dep10;
        r_bad11  <= r_bad10;
        r_clip11 <= r_clip10;
        r_den11  <= r_den10;
    end

    // divider input: magnitude plus half the divisor, rounds half away from zero
    logic                negx, negy;
    logic [PROD_W-1:0]   magx, magy;
    logic [NUM_W-1:0]    numx, numy;
    logic [TAG_W-1:0]    tag_in, tag_out;
    logic                div_vld;
    logic [QUO_W-1:0]    quo_x, quo_y;

    assign negx   = r_px11[PROD_W-1];
    assign negy   = r_py11[PROD_W-1];
    assign magx   = negx ? PROD_W'(-r_px11) : PROD_W'(r_px11);
    assign magy   = negy ? PROD_W'(-r_py11) : PROD_W'(r_py11);
    assign numx   = NUM_W'(magx) + NUM_W'(r_den11 >> 1);
    assign numy   = NUM_W'(magy) + NUM_W'(r_den11 >> 1);
    assign tag_in = {r_dep11, r_bad11, r_clip11, negx, negy};

    prp_div #(
        .DW (DIV_W),
        .NW (NUM_W),
        .QB (QUO_W),
        .TW (TAG_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_vld[11]),
        .i_num_x (numx),
        .i_num_y (numy),
        .i_den   (r_den11),
        .i_tag   (tag_in),
        .o_vld   (div_vld),
        .o_quo_x (quo_x),
        .o_quo_y (quo_y),
        .o_tag   (tag_out)
    );

    // final stage: restore sign, add half screen, saturate
    logic                     t_bad, t_clip, t_negx, t_negy;
    logic [OUT_W-1:0]         t_dep;
    logic signed [QUO_W+1:0]  rx, ry;
    logic [OUT_W:0]           n_sx, n_sy;
    logic [HALF_W-1:0]        half_w, half_h;

    assign {t_dep, t_bad, t_clip, t_negx, t_negy} = tag_out;
    assign half_w = r_screen[11:1];
    assign half_h = r_screen[23:13];
    assign rx = t_negx ? -$signed({2'b00, quo_x}) : $signed({2'b00, quo_x});
    assign ry = t_negy ? -$signed({2'b00, quo_y}) : $signed({2'b00, quo_y});
    assign n_sx = sat_out(64'(rx) + 64'(half_w));
    assign n_sy = sat_out(64'(ry) + 64'(half_h));

    logic                    r_ovld;
    logic signed [OUT_W-1:0] r_sx, r_sy, r_dep;
    logic                    r_bad, r_clip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else begin
            r_ovld <= div_vld;
        end
        r_sx   <= t_bad ? '0 : n_sx[OUT_W-1:0];
        r_sy   <= t_bad ? '0 : n_sy[OUT_W-1:0];
        r_dep  <= t_dep;
        r_bad  <= t_bad;
        r_clip <= t_clip | (~t_bad & (n_sx[OUT_W] | n_sy[OUT_W]));
    end

    assign o_valid           = r_ovld;
    assign o_screen_x        = r_sx;
    assign o_screen_y        = r_sy;
    assign o_depth           = r_dep;
    assign o_divisor_invalid = r_bad;
    assign o_clipped         = r_clip;

endmodule

@@ dv/point_rotate_project_tb.sv @@
`timescale 1ns / 100ps

module point_rotate_project_tb;
    import prp_pkg::*;

    localparam int CB = COORD_BITS_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 50;

    typedef struct packed {
        logic signed [CB-1:0] x;
        logic signed [CB-1:0] y;
        logic signed [CB-1:0] z;
    } t_point;

    typedef struct packed {
        logic signed [OUT_W-1:0] sx;
        logic signed [OUT_W-1:0] sy;
        logic signed [OUT_W-1:0] depth;
        logic                    bad_div;
        logic                    clip;
    } t_screen_pt;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    logic o_busy;
    logic signed [CB-1:0] i_point_x = '0;
    logic signed [CB-1:0] i_point_y = '0;
    logic signed [CB-1:0] i_point_z = '0;
    logic i_cfg_we = 1'b0;
    logic [IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic o_valid;
    logic signed [OUT_W-1:0] o_screen_x, o_screen_y, o_depth;
    logic o_divisor_invalid, o_clipped;

    // mirror of the block's registers
    logic [CFG_W-1:0]   center_r = CENTER_RST;
    logic [Q_W_CFG-1:0] scale_r  = SCALE_RST;
    logic [Q_W_CFG-1:0] sine_r   = SINE_RST;
    logic [Q_W_CFG-1:0] cosine_r = COSINE_RST;
    logic [CFG_W-1:0]   shift_r  = SHIFT_RST;
    logic [SCR_W-1:0]   screen_r = SCREEN_RST;
    logic               persp_r  = 1'b1;
    logic [VD_W-1:0]    vdist_r  = VDIST_RST;

    t_point     pending_points[$];
    t_screen_pt expected_screen[$];
    int idle_pct = 0;
    int mismatches = 0;
    int cycles = 0;

    point_rotate_project dut (.*);

    always #2 i_clk = ~i_clk;

    function automatic logic signed [63:0] coord_of(input logic [CFG_W-1:0] r, input int k);
        logic signed [CB-1:0] c;
        c = r[k*CB +: CB];
        return 64'(c);
    endfunction

    function automatic logic signed [63:0] q_of(input logic [Q_W_CFG-1:0] r, input int k);
        logic signed [15:0] q;
        q = r[k*16 +: 16];
        return 64'(q);
    endfunction

    function automatic logic signed [63:0] round_q14(input logic signed [63:0] v);
        return (v + 64'sd8192) >>> 14;
    endfunction

    function automatic logic signed [63:0] clamp(input logic signed [63:0] v,
            input logic signed [63:0] lo, input logic signed [63:0] hi, inout logic clip);
        if (v > hi) begin
            clip = 1'b1;
            return hi;
        end
        if (v < lo) begin
            clip = 1'b1;
            return lo;
        end
        return v;
    endfunction

    function automatic logic signed [63:0] perspective_div(input logic signed [63:0] q,
            input logic signed [63:0] d);
        logic signed [63:0] p, mag, r;
        p = q * 64'(vdist_r);
        mag = p < 0 ? -p : p;
        r = (mag + d / 2) / d;
        return p < 0 ? -r : r;
    endfunction

    function automatic t_screen_pt project_point(input t_point pt);
        t_screen_pt res;
        logic clip;
        logic signed [63:0] s[3];
        logic signed [63:0] p[3];
        logic signed [63:0] snx, sny, snz, csx, csy, csz;
        logic signed [63:0] t, a, b, shz, qx, qy, qz, dep, dv, sx, sy;
        clip = 1'b0;
        p[0] = 64'(pt.x);
        p[1] = 64'(pt.y);
        p[2] = 64'(pt.z);
        for (int k = 0; k < 3; k++)
            s[k] = clamp((p[k] - coord_of(center_r, k)) * q_of(scale_r, k),
                         -LIM40, LIM40, clip);
        snx = q_of(sine_r, 0);   sny = q_of(sine_r, 1);   snz = q_of(sine_r, 2);
        csx = q_of(cosine_r, 0); csy = q_of(cosine_r, 1); csz = q_of(cosine_r, 2);
        t = round_q14(csz * s[0] + snz * s[1]);
        a = round_q14(csy * s[2] + sny * t);
        b = round_q14(csz * s[1] - snz * s[0]);
        shz = coord_of(shift_r, 2) * 256;
        qx = round_q14(csy * t - sny * s[2]) + coord_of(shift_r, 0) * 256;
        qy = round_q14(snx * a + csx * b) + coord_of(shift_r, 1) * 256;
        qz = round_q14(csx * a - snx * b) + shz;
        dep = clamp((qz + 128) >>> 8, OUT_MIN, OUT_MAX, clip);
        dv = persp_r ? qz : shz;
        sx = 0;
        sy = 0;
        res.bad_div = (dv <= 0);
        if (!res.bad_div) begin
            qx = clamp(qx, -LIM40, LIM40, clip);
            qy = clamp(qy, -LIM40, LIM40, clip);
            sx = perspective_div(qx, dv) + 64'(screen_r[11:0] >> 1);
            sy = perspective_div(qy, dv) + 64'(screen_r[23:12] >> 1);
            sx = clamp(sx, OUT_MIN, OUT_MAX, clip);
            sy = clamp(sy, OUT_MIN, OUT_MAX, clip);
        end
        res.sx = sx[OUT_W-1:0];
        res.sy = sy[OUT_W-1:0];
        res.depth = dep[OUT_W-1:0];
        res.clip = clip;
        return res;
    endfunction

    // driver: hold a request until taken, then pull the next point or idle
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (i_start && !o_busy)
                expected_screen.push_back(project_point({i_point_x, i_point_y, i_point_z}));
            if (!(i_start && o_busy)) begin
                if (pending_points.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    t_point nxt;
                    nxt = pending_points.pop_front();
                    i_start <= 1'b1;
                    i_point_x <= nxt.x;
                    i_point_y <= nxt.y;
                    i_point_z <= nxt.z;
                end else begin
                    i_start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            t_screen_pt exp_r, got;
            got = '{o_screen_x, o_screen_y, o_depth, o_divisor_invalid, o_clipped};
            if (expected_screen.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected result sx=%0d sy=%0d depth=%0d", got.sx, got.sy,
                             got.depth);
            end else begin
                exp_r = expected_screen.pop_front();
                if (got !== exp_r) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch: exp sx=%0d sy=%0d d=%0d inv=%b clip=%b",
                                 exp_r.sx, exp_r.sy, exp_r.depth, exp_r.bad_div, exp_r.clip,
                                 " / got sx=%0d sy=%0d d=%0d inv=%b clip=%b",
                                 got.sx, got.sy, got.depth, got.bad_div, got.clip);
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout");
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        case (idx)
            REG_CENTER: center_r = val;
            REG_SCALE:  scale_r  = val[Q_W_CFG-1:0];
            REG_SINE:   sine_r   = val[Q_W_CFG-1:0];
            REG_COSINE: cosine_r = val[Q_W_CFG-1:0];
            REG_SHIFT:  shift_r  = val;
            REG_SCREEN: screen_r = val[SCR_W-1:0];
            REG_PERSP:  persp_r  = val[0];
            REG_VDIST:  vdist_r  = val[VD_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [CFG_W-1:0] rand63();
        return CFG_W'({$urandom, $urandom});
    endfunction

    function automatic logic [15:0] trig_val();
        case ($urandom_range(5))
            0: return 16'h4000;
            1: return 16'hC000;
            2: return 16'd11585;
            3: return -16'sd11585;
            4: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [CB-1:0] rand_coord();
        case ($urandom_range(9))
            0: return 21'($urandom);
            1: return $urandom_range(1) ? 21'sh0FFFFF : 21'sh100000;
            default: return 21'($signed($urandom_range(4000)) - 2000);
        endcase
    endfunction

    task automatic random_config();
        logic [CFG_W-1:0] v;
        write_reg(REG_CENTER, $urandom_range(3) == 0 ? rand63() :
                  {21'($urandom_range(400)), 21'($urandom_range(400)), 21'($urandom_range(400))});
        for (int k = 0; k < 3; k++)
            v[k*16 +: 16] = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(768));
        write_reg(REG_SCALE, 63'(v[47:0]));
        v = '0;
        for (int k = 0; k < 3; k++) v[k*16 +: 16] = trig_val();
        write_reg(REG_SINE, v);
        v = '0;
        for (int k = 0; k < 3; k++) v[k*16 +: 16] = trig_val();
        write_reg(REG_COSINE, v);
        write_reg(REG_SHIFT, $urandom_range(3) == 0 ? rand63() :
                  {21'($urandom_range(200000)), 21'($urandom), 21'($urandom)});
        write_reg(REG_SCREEN, 63'($urandom));
        write_reg(REG_PERSP, 63'($urandom_range(1)));
        write_reg(REG_VDIST, 63'($urandom_range(3) == 0 ? $urandom : $urandom_range(5000)));
    endtask

    // hold off until every queued point has been sent and its result checked
    task automatic wait_drained();
        while (pending_points.size() != 0 || i_start || expected_screen.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        t_point pt;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: defaults, extremes, zero and negative depth
        pending_points.push_back('{21'sd0, 21'sd0, 21'sd0});
        pending_points.push_back('{21'sh0FFFFF, 21'sh0FFFFF, 21'sh0FFFFF});
        pending_points.push_back('{21'sh100000, 21'sh100000, 21'sh100000});
        pending_points.push_back('{21'sd100, -21'sd50, -21'sd12000});
        pending_points.push_back('{21'sd10, 21'sd20, -21'sd11999});
        pending_points.push_back('{21'sd300, -21'sd300, 21'sd500});
        wait_drained();

        // extreme register values with perspective off: saturation paths
        write_reg(REG_CENTER, '1);
        write_reg(REG_SCALE, 63'h7FFF7FFF7FFF);
        write_reg(REG_SINE, 63'h7FFF80007FFF);
        write_reg(REG_COSINE, 63'h80007FFF8000);
        write_reg(REG_SHIFT, {21'sd1, 21'sh0FFFFF, 21'sh100000});
        write_reg(REG_SCREEN, 63'hFFFFFF);
        write_reg(REG_PERSP, 63'd0);
        write_reg(REG_VDIST, 63'hFFFFF);
        pending_points.push_back('{21'sh0FFFFF, 21'sh100000, 21'sh0FFFFF});
        pending_points.push_back('{21'sh100000, 21'sh0FFFFF, 21'sh100000});
        pending_points.push_back('{21'sd5, 21'sd5, 21'sd5});
        wait_drained();

        write_reg(REG_CENTER, '0);
        write_reg(REG_SCALE, '0);
        write_reg(REG_SHIFT, '0);
        write_reg(REG_SCREEN, '0);
        write_reg(REG_VDIST, '0);
        pending_points.push_back('{21'sd7, -21'sd7, 21'sd9});
        wait_drained();

        for (int ph = 0; ph < 8; ph++) begin
            random_config();
            case (ph % 4)
                0: idle_pct = 0;
                1: idle_pct = 70;
                2: idle_pct = 20;
                default: idle_pct = 0;
            endcase
            for (int n = 0; n < 80; n++) begin
                pt.x = rand_coord();
                pt.y = rand_coord();
                pt.z = rand_coord();
                pending_points.push_back(pt);
            end
            wait_drained();
        end

        if (expected_screen.size() != 0) mismatches = mismatches + 1;
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ files.f @@
hdl/prp_pkg.sv
hdl/prp_div.sv
hdl/point_rotate_project.sv
dv/point_rotate_project_tb.sv
